// ===== design/rrts_pkg.sv =====
`default_nettype none
package rrts_pkg;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_SWITCH  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOCHANGE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_REJECT   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_REFUSED  = 3'd5
  } status_e;

  localparam logic [31:0] IdMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] target_id;
    logic        may_block;
    logic [63:0] space_root;
    logic [63:0] start_addr;
    logic [63:0] stack_word;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] chosen_id;
    logic [63:0] run_root;
    logic [63:0] run_addr;
    logic [63:0] run_stack;
    logic [31:0] ids_issued;
  } rsp_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_SCAN_START,
    CMD_SCAN_STEP,
    CMD_ADD_COMMIT,
    CMD_REMOVE_COMMIT,
    CMD_BLOCK_COMMIT,
    CMD_UNBLOCK_COMMIT,
    CMD_SWITCH_FIRST,
    CMD_SWITCH_SAVE,
    CMD_WALK_STEP,
    CMD_SWITCH_DONE
  } cmd_e;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic free_found;
    logic may_block;
    logic is_last;
    logic ring_nonempty;
    logic switched_once;
    logic counter_max;
    logic walk_done;
    logic walk_moves;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/rrts_if.sv =====
`default_nettype none
interface rrts_req_if;
  logic          valid;
  logic          ready;
  rrts_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface rrts_rsp_if;
  logic          valid;
  logic          ready;
  rrts_pkg::rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/rrts_datapath.sv =====
`default_nettype none
module rrts_datapath #(
  parameter int unsigned MaxTasks = 16,
  parameter int unsigned SlotW = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rrts_pkg::cmd_e cmd_i,
  input  wire rrts_pkg::req_t req_i,
  output rrts_pkg::stat_t     stat_o,
  output logic [31:0]         run_id_o,
  output logic [63:0]         run_root_o,
  output logic [63:0]         run_addr_o,
  output logic [63:0]         run_stack_o,
  output logic [31:0]         id_counter_o
);

  logic [MaxTasks-1:0] used_q;
  logic [31:0]         id_q     [MaxTasks];
  logic                mayb_q   [MaxTasks];
  logic                blk_q    [MaxTasks];
  logic [SlotW-1:0]    fwd_q    [MaxTasks];
  logic [SlotW-1:0]    back_q   [MaxTasks];
  logic [63:0]         root_q   [MaxTasks];
  logic [63:0]         entry_q  [MaxTasks];
  logic [63:0]         stack_q  [MaxTasks];
  logic [SlotW-1:0]    head_q;
  logic                nonempty_q;
  logic [31:0]         idc_q;
  logic                once_q;

  logic [SlotW:0]   idx_q;
  logic             found_q, free_found_q;
  logic [SlotW-1:0] hit_q, free_q;
  logic [SlotW-1:0] walk_q;
  logic [SlotW:0]   wcnt_q;
  logic [SlotW-1:0] sel_q;

  logic [SlotW-1:0] idx_s;
  logic [SlotW-1:0] nx_s, pv_s, tail_s, wnx_s;
  assign idx_s  = idx_q[SlotW-1:0];
  assign nx_s   = fwd_q[hit_q];
  assign pv_s   = back_q[hit_q];
  assign tail_s = back_q[head_q];
  assign wnx_s  = fwd_q[walk_q];

  always_comb begin
    stat_o.scan_done     = (idx_q == (SlotW+1)'(MaxTasks));
    stat_o.found         = found_q;
    stat_o.free_found    = free_found_q;
    stat_o.may_block     = mayb_q[hit_q];
    stat_o.is_last       = (nx_s == hit_q);
    stat_o.ring_nonempty = nonempty_q;
    stat_o.switched_once = once_q;
    stat_o.counter_max   = (idc_q == rrts_pkg::IdMax);
    stat_o.walk_done     = (walk_q == head_q) || !blk_q[walk_q] ||
                           (wcnt_q == (SlotW+1)'(MaxTasks));
    stat_o.walk_moves    = (walk_q != head_q) && !blk_q[walk_q];
  end

  assign run_id_o     = id_q[sel_q];
  assign run_root_o   = root_q[sel_q];
  assign run_addr_o   = entry_q[sel_q];
  assign run_stack_o  = stack_q[sel_q];
  assign id_counter_o = idc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      idc_q        <= '0;
      once_q       <= 1'b0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= '0;
      free_q       <= '0;
      walk_q       <= '0;
      wcnt_q       <= '0;
      sel_q        <= '0;
    end else begin
      case (cmd_i)
        rrts_pkg::CMD_SCAN_START: begin
          idx_q        <= '0;
          found_q      <= 1'b0;
          free_found_q <= 1'b0;
        end
        rrts_pkg::CMD_SCAN_STEP: begin
          if (used_q[idx_s] && id_q[idx_s] == req_i.target_id) begin
            found_q <= 1'b1;
            hit_q   <= idx_s;
          end
          if (!used_q[idx_s] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= idx_s;
          end
          idx_q <= idx_q + 1'b1;
        end
        rrts_pkg::CMD_ADD_COMMIT: begin
          idc_q           <= idc_q + 32'd1;
          used_q[free_q]  <= 1'b1;
          id_q[free_q]    <= idc_q + 32'd1;
          mayb_q[free_q]  <= req_i.may_block;
          blk_q[free_q]   <= 1'b0;
          root_q[free_q]  <= req_i.space_root;
          entry_q[free_q] <= req_i.start_addr;
          stack_q[free_q] <= req_i.stack_word;
          if (!nonempty_q) begin
            head_q         <= free_q;
            fwd_q[free_q]  <= free_q;
            back_q[free_q] <= free_q;
            nonempty_q     <= 1'b1;
          end else begin
            fwd_q[tail_s]  <= free_q;
            back_q[free_q] <= tail_s;
            fwd_q[free_q]  <= head_q;
            back_q[head_q] <= free_q;
          end
        end
        rrts_pkg::CMD_REMOVE_COMMIT: begin
          if (head_q == hit_q) head_q <= nx_s;
          fwd_q[pv_s]   <= nx_s;
          back_q[nx_s]  <= pv_s;
          used_q[hit_q] <= 1'b0;
        end
        rrts_pkg::CMD_BLOCK_COMMIT:   blk_q[hit_q] <= 1'b1;
        rrts_pkg::CMD_UNBLOCK_COMMIT: blk_q[hit_q] <= 1'b0;
        rrts_pkg::CMD_SWITCH_FIRST: begin
          once_q <= 1'b1;
          sel_q  <= head_q;
        end
        rrts_pkg::CMD_SWITCH_SAVE: begin
          stack_q[head_q] <= req_i.stack_word;
          walk_q          <= fwd_q[head_q];
          wcnt_q          <= '0;
        end
        rrts_pkg::CMD_WALK_STEP: begin
          walk_q <= wnx_s;
          wcnt_q <= wcnt_q + 1'b1;
        end
        rrts_pkg::CMD_SWITCH_DONE: begin
          if (walk_q == head_q || blk_q[walk_q]) begin
            sel_q <= head_q;
          end else begin
            head_q <= walk_q;
            sel_q  <= walk_q;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == rrts_pkg::CMD_ADD_COMMIT |=> nonempty_q)
    else $error("ring empty after add");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == rrts_pkg::CMD_SWITCH_FIRST |=> once_q)
    else $error("first switch not recorded");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == rrts_pkg::CMD_ADD_COMMIT |=> idc_q == $past(idc_q) + 32'd1)
    else $error("id counter did not advance");

endmodule
`default_nettype wire

// ===== design/rrts_ctrl.sv =====
`default_nettype none
module rrts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [2:0]      opcode_i,
  input  wire logic            words_zero_i,
  input  wire rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_e       cmd_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [2:0]           status_o,
  output logic                 report_o,
  output logic                 latch_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_WALK, S_FINISH, S_OUT
  } state_e;

  state_e      state_q;
  logic [2:0]  op_q;
  logic        zero_q;
  logic [2:0]  status_q;
  logic        report_q;
  logic        ovalid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign status_o    = status_q;
  assign report_o    = report_q;
  assign latch_o     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = rrts_pkg::CMD_NONE;
    case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o = rrts_pkg::CMD_SCAN_START;
      S_SCAN:   if (!stat_i.scan_done) cmd_o = rrts_pkg::CMD_SCAN_STEP;
      S_DECIDE: begin
        case (op_q)
          rrts_pkg::OP_ADD:
            if (!zero_q && !stat_i.counter_max && stat_i.free_found)
              cmd_o = rrts_pkg::CMD_ADD_COMMIT;
          rrts_pkg::OP_REMOVE:
            if (stat_i.found && !stat_i.is_last) cmd_o = rrts_pkg::CMD_REMOVE_COMMIT;
          rrts_pkg::OP_BLOCK:
            if (stat_i.found && stat_i.may_block) cmd_o = rrts_pkg::CMD_BLOCK_COMMIT;
          rrts_pkg::OP_UNBLOCK:
            if (stat_i.found) cmd_o = rrts_pkg::CMD_UNBLOCK_COMMIT;
          rrts_pkg::OP_SWITCH:
            if (stat_i.ring_nonempty)
              cmd_o = stat_i.switched_once ? rrts_pkg::CMD_SWITCH_SAVE
                                           : rrts_pkg::CMD_SWITCH_FIRST;
          default: ;
        endcase
      end
      S_WALK:   cmd_o = stat_i.walk_done ? rrts_pkg::CMD_SWITCH_DONE
                                         : rrts_pkg::CMD_WALK_STEP;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      zero_q   <= 1'b0;
      status_q <= '0;
      report_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            zero_q  <= words_zero_i;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: if (stat_i.scan_done) state_q <= S_DECIDE;
        S_DECIDE: begin
          report_q <= 1'b0;
          state_q  <= S_OUT;
          ovalid_q <= 1'b1;
          case (op_q)
            rrts_pkg::OP_ADD:
              status_q <= (!zero_q && !stat_i.counter_max && stat_i.free_found)
                          ? rrts_pkg::ST_OK : rrts_pkg::ST_REJECT;
            rrts_pkg::OP_REMOVE:
              status_q <= !stat_i.found ? rrts_pkg::ST_NOTFOUND :
                          stat_i.is_last ? rrts_pkg::ST_REFUSED : rrts_pkg::ST_OK;
            rrts_pkg::OP_BLOCK:
              status_q <= !stat_i.found ? rrts_pkg::ST_NOTFOUND :
                          stat_i.may_block ? rrts_pkg::ST_OK : rrts_pkg::ST_NOCHANGE;
            rrts_pkg::OP_UNBLOCK:
              status_q <= stat_i.found ? rrts_pkg::ST_OK : rrts_pkg::ST_NOTFOUND;
            rrts_pkg::OP_SWITCH: begin
              if (!stat_i.ring_nonempty) begin
                status_q <= rrts_pkg::ST_EMPTY;
              end else if (!stat_i.switched_once) begin
                status_q <= rrts_pkg::ST_OK;
                report_q <= 1'b1;
              end else begin
                ovalid_q <= 1'b0;
                state_q  <= S_WALK;
              end
            end
            default: status_q <= rrts_pkg::ST_REJECT;
          endcase
        end
        S_WALK: begin
          if (stat_i.walk_done) begin
            status_q <= stat_i.walk_moves ? rrts_pkg::ST_OK : rrts_pkg::ST_NOCHANGE;
            state_q  <= S_FINISH;
          end
        end
        S_FINISH: begin
          report_q <= 1'b1;
          ovalid_q <= 1'b1;
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) begin
            ovalid_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> state_q == S_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(status_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_o |=> state_q == S_SCAN)
    else $error("accepted transaction not started");

endmodule
`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// Round-robin task scheduler with blocking.
// One request channel (req) carries an opcode and operands; one response
// channel (rsp) returns exactly one result per request, in order.
// Both channels transfer a transaction when valid and ready are high together.
// The block handles one transaction at a time: req ready is high only when idle.
// Add, remove, block, unblock and an empty or first switch pass through the
// slot scan, which checks one slot per cycle, then the decide and output states.
// A regular switch also saves the stack word and walks the ring from the head
// to the next task that is not blocked, if any, then passes the finish state.
// The result is held in an output register; while the receiver stalls,
// rsp valid and the payload hold and no new request is accepted.
// Reset is asynchronous and active low; it empties the ring, clears the
// id counter and the first-switch flag. No clearing pass is needed.
`default_nettype none
module round_robin_task_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rrts_req_if.sink  req,
  rrts_rsp_if.source rsp
);

  localparam int unsigned SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  rrts_pkg::req_t  req_q;
  rrts_pkg::cmd_e  cmd;
  rrts_pkg::stat_t stat;
  logic            latch, report;
  logic [2:0]      status;
  logic [31:0]     run_id, idc;
  logic [63:0]     run_root, run_addr, run_stack;
  logic            words_zero;

  assign words_zero = (req.payload.space_root == 64'd0) ||
                      (req.payload.start_addr == 64'd0) ||
                      (req.payload.stack_word == 64'd0);

  always_ff @(posedge clk_i) begin
    if (latch) req_q <= req.payload;
  end

  rrts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req.valid),
    .in_ready_o   (req.ready),
    .opcode_i     (req.payload.opcode),
    .words_zero_i (words_zero),
    .stat_i       (stat),
    .cmd_o        (cmd),
    .out_valid_o  (rsp.valid),
    .out_ready_i  (rsp.ready),
    .status_o     (status),
    .report_o     (report),
    .latch_o      (latch)
  );

  rrts_datapath #(.MaxTasks(MAX_TASKS), .SlotW(SlotW)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_i        (req_q),
    .stat_o       (stat),
    .run_id_o     (run_id),
    .run_root_o   (run_root),
    .run_addr_o   (run_addr),
    .run_stack_o  (run_stack),
    .id_counter_o (idc)
  );

  always_comb begin
    rsp.payload.status     = status;
    rsp.payload.chosen_id  = report ? run_id :
                             (req_q.opcode == rrts_pkg::OP_ADD &&
                              status == rrts_pkg::ST_OK) ? idc : 32'd0;
    rsp.payload.run_root   = report ? run_root : 64'd0;
    rsp.payload.run_addr   = report ? run_addr : 64'd0;
    rsp.payload.run_stack  = report ? run_stack : 64'd0;
    rsp.payload.ids_issued = idc;
  end

endmodule
`default_nettype wire
